FILE: src/drse_pkg.sv
`timescale 1ns / 1ps

package drse_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_RULES   = 16;
  localparam int DEF_RELAY_COUNT = 4;

  // Fixed field widths
  localparam int MIN_W   = 11;
  localparam int RELAY_W = 3;
  localparam int RULE_W  = RELAY_W + 2 * MIN_W;
  localparam int DLY_W   = 12;

  localparam logic [MIN_W-1:0] DAY_MINUTES    = 11'd1440;
  localparam logic [DLY_W-1:0] NO_EVENT_DELAY = 12'd1441;

  // Operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // Relay modes
  localparam logic [1:0] MODE_MANUAL   = 2'd0;
  localparam logic [1:0] MODE_SCHEDULE = 2'd1;
  localparam logic [1:0] MODE_ASTRO    = 2'd2;

  // Relay status codes
  localparam logic [2:0] ST_FOLLOW  = 3'd0;
  localparam logic [2:0] ST_ON      = 3'd1;
  localparam logic [2:0] ST_OFF     = 3'd2;
  localparam logic [2:0] ST_NO_RULE = 3'd3;
  localparam logic [2:0] ST_PAUSED  = 3'd4;

  // Event kinds
  localparam logic [1:0] EV_NONE      = 2'd0;
  localparam logic [1:0] EV_TIME_BAD  = 2'd1;
  localparam logic [1:0] EV_NO_SCHED  = 2'd2;
  localparam logic [1:0] EV_FOUND     = 2'd3;

  typedef struct packed {
    logic             op;
    logic [3:0]       rule_index;
    logic [2:0]       rule_relay;
    logic [MIN_W-1:0] rule_on_minute;
    logic [MIN_W-1:0] rule_off_minute;
    logic             time_valid;
    logic [MIN_W-1:0] now_minute;
    logic [1:0]       mode_0;
    logic [1:0]       mode_1;
    logic [1:0]       mode_2;
    logic [1:0]       mode_3;
  } drse_in_t;

  typedef struct packed {
    logic [3:0]       drive_mask;
    logic [3:0]       level_mask;
    logic [2:0]       status_0;
    logic [2:0]       status_1;
    logic [2:0]       status_2;
    logic [2:0]       status_3;
    logic [1:0]       event_kind;
    logic [1:0]       event_relay;
    logic [MIN_W-1:0] event_minute;
    logic             event_turns_on;
  } drse_out_t;

  typedef struct packed {
    logic [RELAY_W-1:0] relay;
    logic [MIN_W-1:0]   on_min;
    logic [MIN_W-1:0]   off_min;
  } drse_rule_t;

  typedef struct packed {
    logic clear;
    logic step;
  } drse_acc_ctrl_t;

  typedef struct packed {
    logic [3:0]       applied;
    logic [3:0]       level;
    logic             found;
    logic [1:0]       ev_relay;
    logic [MIN_W-1:0] ev_minute;
    logic             ev_turns_on;
  } drse_acc_res_t;

endpackage

FILE: src/daily_relay_schedule_evaluator_core.sv
`timescale 1ns / 1ps

// Daily relay schedule evaluator.
// Input channel (in_valid/in_ready/in_data) carries load and evaluate
// transactions. A load writes one rule into the rule RAM in the accepting
// cycle and returns nothing. An evaluate walks the rules in use, one RAM read
// per cycle, and returns one result transaction on out_valid/out_ready/out_data.
// An evaluate latches the transaction, issues one read per rule in use (the
// rule count, saturated to MAX_RULES) through the registered RAM into the
// accumulator, then loads the result register; the walk is skipped when the
// time is invalid, the schedule is disabled or no rules are in use. One
// evaluate is in flight at a time, and the next transaction is taken in the
// cycle after the result register loads. A load keeps the block idle.
// The result sits in an output register: a new transaction is accepted while
// it waits. If the receiver stalls and another result is ready, the block
// holds it and stops accepting until the register frees.
// Configuration: APB-style port, schedule_enable at 0x0, rule_count at 0x4;
// write only while idle. Reset clears both registers and the control state;
// rule RAM contents are undefined until loaded.
module daily_relay_schedule_evaluator_core #(
  parameter int MAX_RULES   = drse_pkg::DEF_MAX_RULES,
  parameter int RELAY_COUNT = drse_pkg::DEF_RELAY_COUNT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  drse_pkg::drse_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output drse_pkg::drse_out_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  import drse_pkg::*;

  localparam int AW    = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W = ($clog2(MAX_RULES + 1) > 5) ? $clog2(MAX_RULES + 1) : 5;

  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_COUNT  = 1'b1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  // Configuration registers
  logic       enable_r;
  logic [4:0] rule_count_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b0;
      rule_count_r <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_ENABLE: enable_r     <= pwdata[0];
        REG_COUNT:  rule_count_r <= pwdata[4:0];
        default:    enable_r     <= enable_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ENABLE: prdata = {31'd0, enable_r};
      REG_COUNT:  prdata = {27'd0, rule_count_r};
      default:    prdata = '0;
    endcase
  end

  // Control state
  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  drse_in_t         item_r, item_nxt;
  drse_out_t        out_r, out_nxt;

  logic             in_acc;
  logic             load_we;
  logic [CNT_W-1:0] count_eff;
  logic             skip_walk;
  logic             out_free;
  logic             issue;
  drse_acc_ctrl_t   acc_ctrl;
  drse_acc_res_t    acc_res;
  drse_rule_t       rd_rule;
  logic [3:0][1:0]  modes;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign count_eff = (CNT_W'(rule_count_r) > CNT_W'(MAX_RULES)) ?
                     CNT_W'(MAX_RULES) : CNT_W'(rule_count_r);
  assign skip_walk = !in_data.time_valid || !enable_r || (count_eff == '0);
  assign load_we   = in_acc && (in_data.op == OP_LOAD) &&
                     (32'(in_data.rule_index) < MAX_RULES);
  assign issue     = (state_r == S_WALK) && (rd_cnt_r != cnt_r);

  assign modes = {item_r.mode_3, item_r.mode_2, item_r.mode_1, item_r.mode_0};

  drse_ram #(
    .WIDTH (RULE_W),
    .DEPTH (MAX_RULES),
    .AW    (AW)
  ) u_rule_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (AW'(in_data.rule_index)),
    .wdata ({in_data.rule_relay, in_data.rule_on_minute, in_data.rule_off_minute}),
    .raddr (rd_cnt_r[AW-1:0]),
    .rdata (rd_rule)
  );

  assign acc_ctrl.clear = in_acc && (in_data.op == OP_EVAL);
  assign acc_ctrl.step  = rd_pend_r;

  drse_acc #(
    .RELAY_COUNT (RELAY_COUNT)
  ) u_acc (
    .clk   (clk),
    .ctrl  (acc_ctrl),
    .rule  (rd_rule),
    .now   (item_r.now_minute),
    .modes (modes),
    .res   (acc_res)
  );

  // Result assembly from the latched transaction and the accumulator
  logic [3:0][2:0] st;
  logic [1:0]      kind;

  always_comb begin
    st   = '0;
    kind = EV_NONE;
    if (!item_r.time_valid) begin
      kind = EV_TIME_BAD;
      for (int i = 0; i < 4; i++) begin
        if (i < RELAY_COUNT &&
            (modes[i] == MODE_SCHEDULE || modes[i] == MODE_ASTRO)) begin
          st[i] = ST_PAUSED;
        end
      end
    end else if (!enable_r || (cnt_r == '0)) begin
      kind = EV_NO_SCHED;
    end else begin
      kind = acc_res.found ? EV_FOUND : EV_NONE;
      for (int i = 0; i < 4; i++) begin
        if (i < RELAY_COUNT && modes[i] == MODE_SCHEDULE) begin
          if (!acc_res.applied[i]) begin
            st[i] = ST_NO_RULE;
          end else begin
            st[i] = acc_res.level[i] ? ST_ON : ST_OFF;
          end
        end
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    rd_cnt_nxt    = rd_cnt_r;
    cnt_nxt       = cnt_r;
    rd_pend_nxt   = issue;
    out_valid_nxt = out_valid_r && !out_ready;
    item_nxt      = item_r;
    out_nxt       = out_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_data.op == OP_EVAL) begin
          item_nxt   = in_data;
          cnt_nxt    = count_eff;
          rd_cnt_nxt = '0;
          state_nxt  = skip_walk ? S_DONE : S_WALK;
        end
      end
      S_WALK: begin
        if (issue) begin
          rd_cnt_nxt = rd_cnt_r + 1'b1;
        end else if (!rd_pend_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_nxt.drive_mask     = (kind == EV_FOUND || kind == EV_NONE) ?
                                   acc_res.applied : 4'd0;
          out_nxt.level_mask     = (kind == EV_FOUND || kind == EV_NONE) ?
                                   (acc_res.applied & acc_res.level) : 4'd0;
          out_nxt.status_0       = st[0];
          out_nxt.status_1       = st[1];
          out_nxt.status_2       = st[2];
          out_nxt.status_3       = st[3];
          out_nxt.event_kind     = kind;
          out_nxt.event_relay    = (kind == EV_FOUND) ? acc_res.ev_relay : 2'd0;
          out_nxt.event_minute   = (kind == EV_FOUND) ? acc_res.ev_minute : '0;
          out_nxt.event_turns_on = (kind == EV_FOUND) && acc_res.ev_turns_on;
          out_valid_nxt          = 1'b1;
          state_nxt              = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_cnt_r    <= '0;
      cnt_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      cnt_r       <= cnt_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: src/drse_ram.sv
`timescale 1ns / 1ps

module drse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: src/drse_acc.sv
`timescale 1ns / 1ps

module drse_acc #(
  parameter int RELAY_COUNT = drse_pkg::DEF_RELAY_COUNT
) (
  input  logic                     clk,
  input  drse_pkg::drse_acc_ctrl_t ctrl,
  input  drse_pkg::drse_rule_t     rule,
  input  logic [10:0]              now,
  input  logic [3:0][1:0]          modes,
  output drse_pkg::drse_acc_res_t  res
);

  import drse_pkg::*;

  logic [3:0]       applied_r, applied_nxt;
  logic [3:0]       level_r, level_nxt;
  logic             found_r, found_nxt;
  logic [1:0]       ev_relay_r, ev_relay_nxt;
  logic [MIN_W-1:0] ev_min_r, ev_min_nxt;
  logic             ev_on_r, ev_on_nxt;
  logic [DLY_W-1:0] best_r, best_nxt;

  logic              use_rule;
  logic              on;
  logic [MIN_W-1:0]  target;
  logic signed [12:0] delta;
  logic [DLY_W-1:0]  adj;
  logic              take;
  logic [1:0]        rel;

  always_comb begin
    rel      = rule.relay[1:0];
    use_rule = (32'(rule.relay) < RELAY_COUNT) && (modes[rel] == MODE_SCHEDULE);
    if (rule.on_min < rule.off_min) begin
      on = (now >= rule.on_min) && (now < rule.off_min);
    end else begin
      on = (now >= rule.on_min) || (now < rule.off_min);
    end
    target = on ? rule.off_min : rule.on_min;
    // wrap past midnight when the target lies before now
    if (target >= now) begin
      delta = $signed({2'b00, target}) - $signed({2'b00, now});
    end else begin
      delta = $signed({2'b00, DAY_MINUTES}) - $signed({2'b00, now})
              + $signed({2'b00, target});
    end
    adj  = (delta == 13'sd0) ? {1'b0, DAY_MINUTES} : delta[DLY_W-1:0];
    take = use_rule && !delta[12] && (adj < best_r);
  end

  always_comb begin
    applied_nxt  = applied_r;
    level_nxt    = level_r;
    found_nxt    = found_r;
    ev_relay_nxt = ev_relay_r;
    ev_min_nxt   = ev_min_r;
    ev_on_nxt    = ev_on_r;
    best_nxt     = best_r;
    if (ctrl.clear) begin
      applied_nxt = '0;
      level_nxt   = '0;
      found_nxt   = 1'b0;
      best_nxt    = NO_EVENT_DELAY;
    end else if (ctrl.step && use_rule) begin
      applied_nxt[rel] = 1'b1;
      level_nxt[rel]   = on;   // last rule on a relay wins
      if (take) begin
        best_nxt     = adj;
        found_nxt    = 1'b1;
        ev_relay_nxt = rel;
        ev_min_nxt   = target;
        ev_on_nxt    = !on;
      end
    end
  end

  always_ff @(posedge clk) begin
    applied_r  <= applied_nxt;
    level_r    <= level_nxt;
    found_r    <= found_nxt;
    ev_relay_r <= ev_relay_nxt;
    ev_min_r   <= ev_min_nxt;
    ev_on_r    <= ev_on_nxt;
    best_r     <= best_nxt;
  end

  always_comb begin
    res.applied     = applied_r;
    res.level       = level_r;
    res.found       = found_r;
    res.ev_relay    = ev_relay_r;
    res.ev_minute   = ev_min_r;
    res.ev_turns_on = ev_on_r;
  end

endmodule
